### src/bdcd_pkg.sv
// Package for the bitmask dictionary code decompressor.
// Holds field widths, stream packing offsets, the command codes and the flip helper.
// No dependencies.
`default_nettype none

package bdcd_pkg;

   // Field widths
   localparam int WORD_W   = 32;
   localparam int CMD_W    = 4;
   localparam int REPS_W   = 3;
   localparam int POS_W    = 5;
   localparam int MASK_W   = 4;
   localparam int INDEX_W  = 4;
   localparam int POSX_W   = POS_W + 1;   // position plus small offset

   // Request tdata packing, lowest bit first
   localparam int RAW_LSB   = 0;
   localparam int REPS_LSB  = RAW_LSB + WORD_W;
   localparam int POSA_LSB  = REPS_LSB + REPS_W;
   localparam int POSB_LSB  = POSA_LSB + POS_W;
   localparam int MASK_LSB  = POSB_LSB + POS_W;
   localparam int INDEX_LSB = MASK_LSB + MASK_W;
   localparam int REQ_BITS  = INDEX_LSB + INDEX_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = WORD_W;

   // Record commands
   typedef enum logic [CMD_W-1:0] {
      CMD_RAW        = 4'd0,
      CMD_REPEAT     = 4'd1,
      CMD_MASK       = 4'd2,
      CMD_FLIP_ONE   = 4'd3,
      CMD_FLIP_TWO   = 4'd4,
      CMD_FLIP_FOUR  = 4'd5,
      CMD_FLIP_PAIR  = 4'd6,
      CMD_DIRECT     = 4'd7,
      CMD_DICT_WRITE = 4'd8
   } cmd_type;

   // One-hot flip pattern for an MSB-first position; positions past the LSB give zero
   function automatic logic [WORD_W-1:0] pos_bit(input logic [POSX_W-1:0] pos);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int k = 0; k < WORD_W; k++) begin
         m[k] = (pos == POSX_W'(WORD_W - 1 - k));
      end
      return m;
   endfunction

endpackage

`default_nettype wire

### src/bitmask_dictionary_code_decompressor_unit.sv
// Bitmask dictionary code decompressor top level; depends on bdcd_pkg.
// A record's request beat is registered in the input stage, and its word then in the output register.
// Throughput: one record per cycle while the response channel is not stalled; a repeat record holds
// the input stage while it sends repeat_count + 1 words, one word per cycle; writes and unused commands emit nothing.
// Reset clears the stage valids, the repeat counter and the previous word;
// the dictionary memory is not cleared and reads undefined until written.
`default_nettype none

module bitmask_dictionary_code_decompressor_unit #(
   parameter int DICT_DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // tdata: raw_word[31:0], repeat_count[34:32], position_a[39:35],
   //        position_b[44:40], mask_bits[48:45], dict_index[52:49], zero pad
   input  wire logic [bdcd_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[3:0]
   input  wire logic [bdcd_pkg::CMD_W-1:0]    req_tuser,
   // Response channel
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // tdata: out_word[31:0]
   output logic [bdcd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tlast: last_of_run
   output logic                               rsp_tlast
);

   import bdcd_pkg::*;

   localparam int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;

   // Request field unpack
   logic                  req_accept;
   logic [CMD_W-1:0]      req_cmd;
   logic [WORD_W-1:0]     req_raw;
   logic [REPS_W-1:0]     req_reps;
   logic [POS_W-1:0]      req_pos_a;
   logic [POS_W-1:0]      req_pos_b;
   logic [MASK_W-1:0]     req_mask;
   logic [INDEX_W-1:0]    req_index;
   logic [AW+INDEX_W-1:0] req_index_ext;
   logic [AW-1:0]         req_addr;
   logic                  req_in_range;

   assign req_accept    = req_tvalid && req_tready;
   assign req_cmd       = req_tuser;
   assign req_raw       = req_tdata[RAW_LSB +: WORD_W];
   assign req_reps      = req_tdata[REPS_LSB +: REPS_W];
   assign req_pos_a     = req_tdata[POSA_LSB +: POS_W];
   assign req_pos_b     = req_tdata[POSB_LSB +: POS_W];
   assign req_mask      = req_tdata[MASK_LSB +: MASK_W];
   assign req_index     = req_tdata[INDEX_LSB +: INDEX_W];
   assign req_index_ext = {{AW{1'b0}}, req_index};
   assign req_addr      = req_index_ext[AW-1:0];
   assign req_in_range  = req_index_ext < (AW+INDEX_W)'(DICT_DEPTH);

   // Dictionary memory: written and read on the request beat
   logic [WORD_W-1:0] dict_mem [DICT_DEPTH];
   logic [WORD_W-1:0] dict_rd_ff;

   always_ff @(posedge clock) begin
      if (req_accept && req_cmd == CMD_DICT_WRITE && req_in_range) begin
         dict_mem[req_addr] <= req_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         dict_rd_ff <= dict_mem[req_addr];
      end
   end

   // Input stage registers
   logic                 s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]     s1_cmd_ff;
   logic [WORD_W-1:0]    s1_raw_ff;
   logic [REPS_W-1:0]    s1_reps_ff;
   logic [POS_W-1:0]     s1_pos_a_ff;
   logic [POS_W-1:0]     s1_pos_b_ff;
   logic [MASK_W-1:0]    s1_mask_ff;
   logic                 s1_in_range_ff;
   logic [REPS_W-1:0]    rep_cnt_ff, rep_cnt_in;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff      <= req_cmd;
         s1_raw_ff      <= req_raw;
         s1_reps_ff     <= req_reps;
         s1_pos_a_ff    <= req_pos_a;
         s1_pos_b_ff    <= req_pos_b;
         s1_mask_ff     <= req_mask;
         s1_in_range_ff <= req_in_range;
      end
   end

   // Word rebuild from the staged record
   logic [POSX_W-1:0] pa0, pa1, pa2, pa3, pb0;
   logic [WORD_W-1:0] base_word;
   logic [WORD_W-1:0] flip_mask;
   logic [WORD_W-1:0] prev_word_ff, prev_word_in;
   logic [WORD_W-1:0] s1_word;
   logic              s1_emits;
   logic              s1_is_repeat;

   assign pa0 = {1'b0, s1_pos_a_ff};
   assign pa1 = pa0 + POSX_W'(1);
   assign pa2 = pa0 + POSX_W'(2);
   assign pa3 = pa0 + POSX_W'(3);
   assign pb0 = {1'b0, s1_pos_b_ff};
   assign base_word = s1_in_range_ff ? dict_rd_ff : '0;

   always_comb begin
      flip_mask    = '0;
      s1_word      = base_word;
      s1_emits     = 1'b1;
      s1_is_repeat = 1'b0;
      case (s1_cmd_ff)
         CMD_RAW: begin
            s1_word = s1_raw_ff;
         end
         CMD_REPEAT: begin
            s1_word      = prev_word_ff;
            s1_is_repeat = 1'b1;
         end
         CMD_MASK: begin
            flip_mask = ({WORD_W{s1_mask_ff[3]}} & pos_bit(pa0))
                      ^ ({WORD_W{s1_mask_ff[2]}} & pos_bit(pa1))
                      ^ ({WORD_W{s1_mask_ff[1]}} & pos_bit(pa2))
                      ^ ({WORD_W{s1_mask_ff[0]}} & pos_bit(pa3));
            s1_word   = base_word ^ flip_mask;
         end
         CMD_FLIP_ONE: begin
            flip_mask = pos_bit(pa0);
            s1_word   = base_word ^ flip_mask;
         end
         CMD_FLIP_TWO: begin
            flip_mask = pos_bit(pa0) ^ pos_bit(pa1);
            s1_word   = base_word ^ flip_mask;
         end
         CMD_FLIP_FOUR: begin
            flip_mask = pos_bit(pa0) ^ pos_bit(pa1) ^ pos_bit(pa2) ^ pos_bit(pa3);
            s1_word   = base_word ^ flip_mask;
         end
         CMD_FLIP_PAIR: begin
            // same position twice cancels out
            flip_mask = pos_bit(pa0) ^ pos_bit(pb0);
            s1_word   = base_word ^ flip_mask;
         end
         CMD_DIRECT: begin
            s1_word = base_word;
         end
         default: begin
            // dictionary write and unused codes produce no word
            s1_emits = 1'b0;
         end
      endcase
   end

   // Stage handoff control
   logic out_free;
   logic s1_fire;
   logic s1_last;
   logic s1_done;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign s1_fire  = s1_valid_ff && s1_emits && out_free;
   assign s1_last  = !s1_is_repeat || (rep_cnt_ff == s1_reps_ff);
   assign s1_done  = s1_valid_ff && (!s1_emits || (out_free && s1_last));
   assign req_tready = !s1_valid_ff || s1_done;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (s1_done) begin
         rep_cnt_in = '0;
      end else if (s1_fire) begin
         rep_cnt_in = rep_cnt_ff + REPS_W'(1);
      end else begin
         rep_cnt_in = rep_cnt_ff;
      end
   end

   // Previous word follows every non-repeat word sent out
   assign prev_word_in = (s1_fire && !s1_is_repeat) ? s1_word : prev_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rep_cnt_ff   <= '0;
         prev_word_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rep_cnt_ff   <= rep_cnt_in;
         prev_word_ff <= prev_word_in;
      end
   end

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_last_ff;

   assign rsp_valid_in = out_free ? s1_fire : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_word_ff <= s1_word;
         rsp_last_ff <= s1_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
